// ===== hdl/ffma_pkg.sv =====
`timescale 1ns / 1ps

package ffma_pkg;

   localparam logic KIND_ALLOC = 1'b0;
   localparam logic KIND_FREE  = 1'b1;

   typedef struct packed {
      logic        kind;
      logic [7:0]  owner_id;
      logic [10:0] block_size;
   } req_type;

   typedef struct packed {
      logic       success;
      logic [9:0] start_address;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_FILL,
      ST_FREE,
      ST_DONE
   } state_type;

endpackage

// ===== hdl/ffma_ram.sv =====
`timescale 1ns / 1ps

module ffma_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/first_fit_memory_allocator.sv =====
`timescale 1ns / 1ps

// First-fit allocator over an owner map held in one RAM of MAP_UNITS words of
// OWNER_BITS bits (zero = free unit). After reset a clearing pass writes zero
// to every unit, one per cycle, so the block takes no request until the pass
// is done. A request is taken only while the sequencer is idle and is worked
// one map unit per cycle through the single read and single write port of the
// map RAM: an allocate scans from unit 0, ending early at the first fitting
// run, and then writes the run one unit a cycle; a free scans the whole map
// and clears matching units in the same pass. A rejected allocate (size zero,
// size above MAP_UNITS, owner zero) ends without touching the map. Each
// request gives exactly one result word; a finished result waits in the
// output register while the next request is taken.
module first_fit_memory_allocator #(
   parameter int MAP_UNITS  = 1024,
   parameter int OWNER_BITS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ffma_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ffma_pkg::rsp_type rsp_data
);

   localparam int AW = $clog2(MAP_UNITS);
   localparam int CW = $clog2(MAP_UNITS + 1);

   ffma_pkg::state_type    state_ff, state_in;
   logic [CW-1:0]          addr_ff, addr_in;     // next unit to read or clear
   logic                   pend_ff, pend_in;     // read data arrives this cycle
   logic [AW-1:0]          pidx_ff, pidx_in;     // unit of the arriving data
   logic [CW-1:0]          run_ff, run_in;
   logic [AW-1:0]          first_ff, first_in;
   logic [CW-1:0]          size_ff, size_in;
   logic [OWNER_BITS-1:0]  own_ff, own_in;
   logic [AW-1:0]          fill_ff, fill_in;
   logic [CW-1:0]          left_ff, left_in;
   ffma_pkg::rsp_type      res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   ffma_pkg::rsp_type      rsp_ff, rsp_in;

   logic                   ram_wr_en;
   logic [AW-1:0]          ram_wr_addr;
   logic [OWNER_BITS-1:0]  ram_wr_data;
   logic                   ram_rd_en;
   logic [AW-1:0]          ram_rd_addr;
   logic [OWNER_BITS-1:0]  ram_rd_data;

   ffma_ram #(
      .WIDTH(OWNER_BITS),
      .DEPTH(MAP_UNITS)
   ) u_map (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ffma_pkg::ST_CLEAR;
         addr_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      pidx_ff  <= pidx_in;
      run_ff   <= run_in;
      first_ff <= first_in;
      size_ff  <= size_in;
      own_ff   <= own_in;
      fill_ff  <= fill_in;
      left_ff  <= left_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   always_comb begin
      logic [OWNER_BITS-1:0] req_own;
      logic                  more;
      logic                  hit;
      logic [AW-1:0]         run_first;

      req_own   = OWNER_BITS'(32'(req_data.owner_id));
      more      = (addr_ff != CW'(MAP_UNITS));
      run_first = (run_ff == '0) ? pidx_ff : first_ff;
      hit       = pend_ff && (ram_rd_data == '0) && (run_ff + CW'(1) == size_ff);

      state_in     = state_ff;
      addr_in      = addr_ff;
      pend_in      = 1'b0;
      pidx_in      = addr_ff[AW-1:0];
      run_in       = run_ff;
      first_in     = first_ff;
      size_in      = size_ff;
      own_in       = own_ff;
      fill_in      = fill_ff;
      left_in      = left_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;

      ram_wr_en    = 1'b0;
      ram_wr_addr  = addr_ff[AW-1:0];
      ram_wr_data  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = addr_ff[AW-1:0];

      req_ready    = (state_ff == ffma_pkg::ST_IDLE);

      case (state_ff)
         ffma_pkg::ST_CLEAR: begin
            // sweep zeros through the map after reset
            ram_wr_en = 1'b1;
            addr_in   = addr_ff + CW'(1);
            if (addr_ff == CW'(MAP_UNITS - 1)) begin
               state_in = ffma_pkg::ST_IDLE;
            end
         end
         ffma_pkg::ST_IDLE: begin
            addr_in = '0;
            run_in  = '0;
            own_in  = req_own;
            size_in = CW'(32'(req_data.block_size));
            if (req_valid) begin
               if (req_data.kind == ffma_pkg::KIND_FREE) begin
                  if (req_own == '0) begin
                     res_in   = '{success: 1'b1, start_address: '0};
                     state_in = ffma_pkg::ST_DONE;
                  end else begin
                     state_in = ffma_pkg::ST_FREE;
                  end
               end else if (req_data.block_size == '0 || req_own == '0 ||
                            32'(req_data.block_size) > 32'(MAP_UNITS)) begin
                  // reject without touching the map
                  res_in   = '{success: 1'b0, start_address: '0};
                  state_in = ffma_pkg::ST_DONE;
               end else begin
                  state_in = ffma_pkg::ST_SCAN;
               end
            end
         end
         ffma_pkg::ST_SCAN: begin
            // issue one read a cycle, judge the word read the cycle before
            if (more) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               addr_in   = addr_ff + CW'(1);
            end
            if (pend_ff) begin
               if (ram_rd_data == '0) begin
                  run_in   = run_ff + CW'(1);
                  first_in = run_first;
               end else begin
                  run_in = '0;
               end
            end
            if (hit) begin
               fill_in  = run_first;
               left_in  = size_ff;
               state_in = ffma_pkg::ST_FILL;
            end else if (!pend_ff && !more) begin
               res_in   = '{success: 1'b0, start_address: '0};
               state_in = ffma_pkg::ST_DONE;
            end
         end
         ffma_pkg::ST_FILL: begin
            ram_wr_en   = 1'b1;
            ram_wr_addr = fill_ff;
            ram_wr_data = own_ff;
            fill_in     = fill_ff + AW'(1);
            left_in     = left_ff - CW'(1);
            if (left_ff == CW'(1)) begin
               res_in   = '{success: 1'b1, start_address: 10'(32'(first_ff))};
               state_in = ffma_pkg::ST_DONE;
            end
         end
         ffma_pkg::ST_FREE: begin
            if (more) begin
               ram_rd_en = 1'b1;
               pend_in   = 1'b1;
               addr_in   = addr_ff + CW'(1);
            end
            // drop the unit if it belongs to the owner being released
            if (pend_ff && ram_rd_data == own_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = pidx_ff;
            end
            if (!pend_ff && !more) begin
               res_in   = '{success: 1'b1, start_address: '0};
               state_in = ffma_pkg::ST_DONE;
            end
         end
         ffma_pkg::ST_DONE: begin
            // hold the result until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = ffma_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ffma_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

`ifndef ASSERT_OFF
   a_fill_owner: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffma_pkg::ST_FILL) |-> (ram_wr_data == own_ff && own_ff != '0))
      else $error("fill writes a free mark or a foreign owner");

   a_free_zero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffma_pkg::ST_FREE && ram_wr_en) |-> (ram_wr_data == '0))
      else $error("free pass writes a nonzero word");

   a_run_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ffma_pkg::ST_SCAN) |-> (run_ff < size_ff))
      else $error("free run overtook the requested size");

   a_fail_start: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.success) |-> (rsp_ff.start_address == '0))
      else $error("failed allocate reports a start unit");
`endif

endmodule
